// ===== design/hgru_pkg.sv =====
// ----------------------------------------------------------------------------
// hgru_pkg
// Shared types, command codes and default sizes for the hemisphere grid
// rectangle update core.
// ----------------------------------------------------------------------------
package hgru_pkg;

  // Default grid limits.
  localparam int DEF_MAX_AZIMUTH   = 512;
  localparam int DEF_MAX_ELEVATION = 128;

  // Fixed field widths.
  localparam int KIND_W = 3;
  localparam int MODE_W = 2;
  localparam int ELEV_W = 9;
  localparam int AZ_W   = 11;
  localparam int CELL_W = 32;
  localparam int DATA_W = 64;
  localparam int CFG_W  = 10;
  localparam int AZ_CFG_W = 10;
  localparam int EL_CFG_W = 8;

  // Reset values of the configuration registers.
  localparam int AZ_RESET = 360;
  localparam int EL_RESET = 90;

  // Configuration register indexes.
  localparam logic REG_AZIMUTH_COUNT   = 1'b0;
  localparam logic REG_ELEVATION_COUNT = 1'b1;

  // Command kinds.
  localparam logic [KIND_W-1:0] KIND_FILL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RECT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUM    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MINMAX = 3'd4;

  // Rectangle operations.
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MUL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_MUL,
    S_SWEEP,
    S_DRAIN,
    S_RD,
    S_CALC,
    S_WR,
    S_DONE
  } state_t;

endpackage

// ===== design/hgru_ram.sv =====
// ----------------------------------------------------------------------------
// hgru_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hgru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hgru_alu.sv =====
// ----------------------------------------------------------------------------
// hgru_alu
// Cell update unit: add, multiply with rounding, or set, saturating to 32 bits.
// ----------------------------------------------------------------------------
module hgru_alu
  import hgru_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [CELL_W-1:0] cell_val,
  input  logic signed [CELL_W-1:0] operand,
  output logic signed [CELL_W-1:0] result
);

  logic [MODE_W-1:0]        mode_q;
  logic signed [CELL_W:0]   sum_q;
  logic signed [63:0]       prod_q;
  logic signed [CELL_W-1:0] op_q;
  logic signed [63:0]       rounded;
  logic signed [47:0]       shifted;

  // First stage: the product and the sum are registered.
  always_ff @(posedge clk) begin
    if (load) begin
      mode_q <= mode;
      op_q   <= operand;
      sum_q  <= (CELL_W+1)'(cell_val) + (CELL_W+1)'(operand);
      prod_q <= 64'(cell_val) * 64'(operand);
    end
  end

  // Second stage: round half up, floor shift, saturate.
  always_comb begin
    rounded = prod_q + 64'sd32768;
    shifted = 48'(rounded >>> 16);
    result  = op_q;
    case (mode_q)
      MODE_ADD: begin
        if (sum_q > (CELL_W+1)'(32'sh7FFFFFFF)) begin
          result = 32'sh7FFFFFFF;
        end else if (sum_q < -(CELL_W+1)'(33'sh080000000)) begin
          result = 32'sh80000000;
        end else begin
          result = sum_q[CELL_W-1:0];
        end
      end
      MODE_MUL: begin
        if (shifted > 48'sh7FFFFFFF) begin
          result = 32'sh7FFFFFFF;
        end else if (shifted < -48'sh80000000) begin
          result = 32'sh80000000;
        end else begin
          result = shifted[CELL_W-1:0];
        end
      end
      default: result = op_q;
    endcase
  end

endmodule

// ===== design/hemisphere_grid_rect_update_core.sv =====
// ----------------------------------------------------------------------------
// hemisphere_grid_rect_update_core
// Azimuth by elevation grid of Q16.16 cells held in one RAM, with fill,
// rectangle update, sum, read and min/max commands.
// ----------------------------------------------------------------------------
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   command   | in_valid/in_ready, kind .. operand        | in
//   result    | out_valid/out_ready, data_value, max_value, error | out
//   config    | cfg_we, cfg_index, cfg_data               | in
//
// After reset the RAM is cleared one cell a cycle, all MAX_AZIMUTH*MAX_ELEVATION
// cells (65536 at the defaults); no command beat is taken during that pass.
// Fill writes every cell in use, one per cycle; sum and min/max read every
// cell in use, the RAM streaming one read per cycle.
// A rectangle first reduces its start column by repeated add or subtract of
// the azimuth count, then reads, computes and writes each cell in turn.
// Commands run one at a time; the result sits in an output register, so the
// next command beat is taken while it waits.
module hemisphere_grid_rect_update_core
  import hgru_pkg::*;
#(
  parameter int MAX_AZIMUTH   = DEF_MAX_AZIMUTH,
  parameter int MAX_ELEVATION = DEF_MAX_ELEVATION
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        kind,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [ELEV_W-1:0] elev_low,
  input  logic signed [ELEV_W-1:0] elev_high,
  input  logic signed [AZ_W-1:0]   az_base_start,
  input  logic signed [AZ_W-1:0]   az_base_end,
  input  logic signed [AZ_W-1:0]   az_top_start,
  input  logic signed [AZ_W-1:0]   az_top_end,
  input  logic signed [CELL_W-1:0] operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] data_value,
  output logic signed [CELL_W-1:0] max_value,
  output logic                     error
);

  localparam int DEPTH = MAX_AZIMUTH * MAX_ELEVATION;
  localparam int AW    = $clog2(DEPTH);
  localparam int AZW   = $clog2(MAX_AZIMUTH + 1);   // holds the azimuth count
  localparam int ELW   = $clog2(MAX_ELEVATION + 1); // holds the elevation count
  localparam int AZI   = $clog2(MAX_AZIMUTH);       // column index
  localparam int ELI   = $clog2(MAX_ELEVATION);     // row index
  localparam int CW    = (AZW + 2 > AZ_W + 1) ? AZW + 2 : AZ_W + 1;
  localparam int EW    = (ELW + 1 > ELEV_W) ? ELW + 1 : ELEV_W;
  localparam int AZ_RST = (AZ_RESET > MAX_AZIMUTH) ? MAX_AZIMUTH : AZ_RESET;
  localparam int EL_RST = (EL_RESET > MAX_ELEVATION) ? MAX_ELEVATION : EL_RESET;

  state_t state, state_next;

  // Configuration.
  logic [AZW-1:0] na;
  logic [ELW-1:0] ne;

  // Command held for the duration of its work.
  logic [KIND_W-1:0]        c_kind;
  logic [MODE_W-1:0]        c_mode;
  logic signed [EW-1:0]     c_elo;
  logic signed [EW-1:0]     c_ehi;
  logic signed [CELL_W-1:0] c_op;

  // Address walk.
  logic signed [CW-1:0] col;
  logic [AZI-1:0]       col0;
  logic [AZI-1:0]       col_cur;
  logic [CW-1:0]        a_span;
  logic [CW-1:0]        a_left;
  logic [ELI-1:0]       e_cur;
  logic [AW-1:0]        row_addr;
  logic [AW-1:0]        addr;
  logic [AZI-1:0]       sa;
  logic [ELI-1:0]       se;

  // Streaming read pipe and reductions.
  logic                     rv;
  logic                     rinc;
  logic                     first;
  logic signed [DATA_W-1:0] acc;
  logic signed [CELL_W-1:0] mn;
  logic signed [CELL_W-1:0] mx;

  // Pending result.
  logic signed [DATA_W-1:0] p_data;
  logic                     p_err;

  // RAM and ALU connections.
  logic                     mem_we;
  logic [CELL_W-1:0]        mem_wdata;
  logic [CELL_W-1:0]        mem_rdata;
  logic signed [CELL_W-1:0] rd_cell;
  logic signed [CELL_W-1:0] alu_result;
  logic                     alu_load;

  // Decode of the incoming beat.
  logic signed [CW-1:0] abs_in, abe_in, ats_in, ate_in, amin_in, amax_in, na_c;
  logic signed [EW-1:0] elo_in, ehi_in, ne_e;
  state_t               start_state;
  logic                 start_err;
  logic                 accept;

  // Address helpers.
  logic [AZI+ELW-1:0] mul_prod;
  logic [AW-1:0]      mul_addr;
  logic               sweep_last;
  logic               rect_row_end;
  logic               rect_last;
  logic               col_wrap;
  logic               out_free;

  // Configuration clamp.
  logic [AZW-1:0] az_cfg;
  logic [ELW-1:0] el_cfg;

  hgru_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(addr),
    .wdata(mem_wdata),
    .raddr(addr),
    .rdata(mem_rdata)
  );

  hgru_alu u_alu (
    .clk     (clk),
    .load    (alu_load),
    .mode    (c_mode),
    .cell_val(rd_cell),
    .operand (c_op),
    .result  (alu_result)
  );

  assign rd_cell = mem_rdata;

  // Written values are clamped into 1..MAX; elevation uses only the low 8 bits.
  always_comb begin
    if (cfg_data == '0) begin
      az_cfg = AZW'(1);
    end else if (32'(cfg_data) > MAX_AZIMUTH) begin
      az_cfg = AZW'(MAX_AZIMUTH);
    end else begin
      az_cfg = AZW'(cfg_data);
    end
    if (cfg_data[EL_CFG_W-1:0] == '0) begin
      el_cfg = ELW'(1);
    end else if (32'(cfg_data[EL_CFG_W-1:0]) > MAX_ELEVATION) begin
      el_cfg = ELW'(MAX_ELEVATION);
    end else begin
      el_cfg = ELW'(cfg_data[EL_CFG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      na <= AZW'(AZ_RST);
      ne <= ELW'(EL_RST);
    end else if (cfg_we) begin
      if (cfg_index == REG_AZIMUTH_COUNT) begin
        na <= az_cfg;
      end else begin
        ne <= el_cfg;
      end
    end
  end

  // Decode of a new command: where it starts and whether it fails at once.
  always_comb begin
    abs_in  = CW'(az_base_start);
    abe_in  = CW'(az_base_end);
    ats_in  = CW'(az_top_start);
    ate_in  = CW'(az_top_end);
    amin_in = (abs_in < ats_in) ? abs_in : ats_in;
    amax_in = (abe_in > ate_in) ? abe_in : ate_in;
    na_c    = $signed({{(CW-AZW){1'b0}}, na});
    elo_in  = EW'(elev_low);
    ehi_in  = EW'(elev_high);
    ne_e    = $signed({{(EW-ELW){1'b0}}, ne});
    start_state = S_DONE;
    start_err   = 1'b0;
    case (kind)
      KIND_FILL:   start_state = S_SWEEP;
      KIND_MINMAX: start_state = S_SWEEP;
      KIND_RECT: begin
        if (elo_in <= ehi_in && amin_in <= amax_in) begin
          if (elo_in < 0 || ehi_in >= ne_e) begin
            start_err = 1'b1;
          end else if (mode != MODE_UNUSED) begin
            start_state = S_MOD;
          end
        end
      end
      KIND_SUM: begin
        if (elo_in < 0) begin
          start_err = 1'b1;
        end else begin
          start_state = S_SWEEP;
        end
      end
      KIND_READ: begin
        if (abs_in < 0 || abs_in >= na_c || elo_in < 0 || elo_in >= ne_e) begin
          start_err = 1'b1;
        end else begin
          start_state = S_MUL;
        end
      end
      default: start_err = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Row start address of a column: col * ne + row.
  assign mul_prod = col[AZI-1:0] * ne;
  assign mul_addr = AW'(mul_prod) + AW'(c_elo[ELI-1:0]);

  assign sweep_last   = (AZW'(sa) == na - 1'b1) && (ELW'(se) == ne - 1'b1);
  assign rect_row_end = (a_left == '0);
  assign rect_last    = rect_row_end && ($signed({{(EW-ELI){1'b0}}, e_cur}) == c_ehi);
  assign col_wrap     = (AZW'(col_cur) + 1'b1 == na);
  assign out_free     = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = start_state;
      S_MOD: begin
        if (col >= 0 && col < na_c) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_RD;
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = (c_kind == KIND_FILL) ? S_DONE : S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_RD:    state_next = S_CALC;
      S_CALC:  state_next = (c_kind == KIND_READ) ? S_DONE : S_WR;
      S_WR:    state_next = rect_last ? S_DONE : S_RD;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    alu_load  = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_CLEAR: mem_we = 1'b1;
      S_SWEEP: begin
        if (c_kind == KIND_FILL) begin
          mem_we    = 1'b1;
          mem_wdata = c_op;
        end
      end
      S_CALC:  alu_load = 1'b1;
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = alu_result;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Datapath of the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      rv   <= 1'b0;
    end else begin
      rv <= (state == S_SWEEP) && (c_kind != KIND_FILL);
      case (state)
        S_CLEAR: addr <= addr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            c_kind <= kind;
            c_mode <= mode;
            c_elo  <= elo_in;
            c_ehi  <= ehi_in;
            c_op   <= operand;
            col    <= (kind == KIND_READ) ? abs_in : amin_in;
            a_span <= CW'(amax_in - amin_in);
            addr   <= '0;
            sa     <= '0;
            se     <= '0;
            acc    <= '0;
            first  <= 1'b1;
            p_data <= '0;
            p_err  <= start_err;
          end
        end
        S_MOD: begin
          if (col < 0) begin
            col <= col + na_c;
          end else if (col >= na_c) begin
            col <= col - na_c;
          end
        end
        S_MUL: begin
          col0     <= col[AZI-1:0];
          col_cur  <= col[AZI-1:0];
          e_cur    <= c_elo[ELI-1:0];
          a_left   <= a_span;
          row_addr <= mul_addr;
          addr     <= mul_addr;
        end
        S_SWEEP: begin
          rinc <= ($signed({{(EW-ELI){1'b0}}, se}) >= c_elo);
          addr <= addr + 1'b1;
          if (ELW'(se) == ne - 1'b1) begin
            se <= '0;
            sa <= sa + 1'b1;
          end else begin
            se <= se + 1'b1;
          end
        end
        S_CALC: begin
          if (c_kind == KIND_READ) begin
            p_data <= DATA_W'(rd_cell);
          end
        end
        S_WR: begin
          if (rect_row_end) begin
            // Next row starts again at the first column.
            e_cur    <= e_cur + 1'b1;
            row_addr <= row_addr + 1'b1;
            addr     <= row_addr + 1'b1;
            col_cur  <= col0;
            a_left   <= a_span;
          end else begin
            a_left <= a_left - 1'b1;
            if (col_wrap) begin
              col_cur <= '0;
              addr    <= AW'(e_cur);
            end else begin
              col_cur <= col_cur + 1'b1;
              addr    <= addr + AW'(ne);
            end
          end
        end
        default: addr <= addr;
      endcase
      // Reductions over the streamed reads.
      if (rv) begin
        first <= 1'b0;
        if (rinc) begin
          acc <= acc + DATA_W'(rd_cell);
        end
        if (first || rd_cell < mn) mn <= rd_cell;
        if (first || rd_cell > mx) mx <= rd_cell;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid  <= 1'b1;
      error      <= p_err;
      max_value  <= '0;
      data_value <= '0;
      if (!p_err) begin
        case (c_kind)
          KIND_SUM:  data_value <= acc;
          KIND_READ: data_value <= p_data;
          KIND_MINMAX: begin
            data_value <= DATA_W'(mn);
            max_value  <= mx;
          end
          default: data_value <= '0;
        endcase
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The RAM is only written while a command or the clearing pass is running.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("RAM written while no command is running");

  // No command beat is taken during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("command taken during clearing pass");

  // A rectangle write always targets a column inside the grid in use.
  a_rect_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (AZW'(col_cur) < na))
    else $error("rectangle column out of range");

  // A rectangle's ALU result is written in the cycle after it was loaded.
  a_alu_seq: assert property (@(posedge clk) disable iff (rst)
    alu_load && c_kind == KIND_RECT |=> (state == S_WR))
    else $error("rectangle write lost its slot");

endmodule
